// ===== design/hrs_pkg.sv =====
// shared types and constants of the heart rate select and sliding median block
package hrs_pkg;

  localparam int unsigned WINDOW_DEPTH = 40;

  localparam logic [15:0] WINDOW_RESET_OLDEST = 16'd12288;
  localparam logic [15:0] CONF_THR_RESET      = 16'd102;
  localparam logic [15:0] DIFF_THR_RESET      = 16'd3840;

  localparam logic [16:0] BREATH_ROUND = 17'd128;
  localparam logic [17:0] MEDIAN_ROUND = 18'd256;
  localparam logic [7:0]  BPM_MAX      = 8'd255;

  // configuration register indexes
  localparam logic CFG_CONF_THR = 1'b0;
  localparam logic CFG_DIFF_THR = 1'b1;

  // one classified frame, front end to back end
  typedef struct packed {
    logic [15:0] chosen;
    logic [7:0]  breath_bpm;
    logic        used_fft;
  } entry_t;

  // queue occupancy seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== design/heart_rate_select_sliding_median.sv =====
// top level of the heart rate select and sliding median block
//
// one input word per radar frame arrives on the s_axis channel: fft and
// peak heart rate estimates, heart confidence and breath rate, all Q8.8
// one result word per frame leaves on the m_axis channel: median heart
// rate and rounded breath rate in whole bpm, tuser flags the fft estimate
// the front end smooths the confidence, picks an estimate and queues it
// in a two-word queue, so it keeps taking words while the back end works
// the back end keeps the window as a sorted row of cells tagged with
// their age; the oldest cell is overwritten and WINDOW_DEPTH odd-even
// compare and swap passes restore order, then the middle cells give the
// median
// an accepted word is registered in the queue; the back end pops it,
// runs the sort passes and loads the output register, and takes no new
// word from the queue until that result is loaded
// a result waits in the output register while m_axis_tready is low; the
// back end finishes one more word and the queue fills, so s_axis_tready
// drops after three more words
// reset clears the queue, loads the default thresholds, zeroes the
// smoothed confidence and sets the window to one 48 bpm entry as the
// oldest and zeros elsewhere
// config writes take effect at once and are meant for an idle block
module heart_rate_select_sliding_median #(
  parameter int unsigned WINDOW_DEPTH = hrs_pkg::WINDOW_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port, index 0 confidence threshold, 1 difference threshold
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // heart_rate_fft[15:0], heart_rate_peak[31:16], heart_confidence[47:32],
  // breath_rate_fft[63:48]
  input  logic [63:0] s_axis_tdata,
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // heart_rate_bpm[7:0], breath_rate_bpm[15:8]
  output logic [15:0] m_axis_tdata,
  // used_fft[0]
  output logic        m_axis_tuser
);

  hrs_pkg::queue_stat_t q_stat;
  hrs_pkg::entry_t      push_entry, pop_entry;
  logic                 push, pop;
  logic [7:0]           heart_bpm, breath_bpm;

  // front end: classify and queue
  hrs_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .heart_rate_fft_i   (s_axis_tdata[15:0]),
    .heart_rate_peak_i  (s_axis_tdata[31:16]),
    .heart_confidence_i (s_axis_tdata[47:32]),
    .breath_rate_fft_i  (s_axis_tdata[63:48]),
    .q_stat_i           (q_stat),
    .push_o             (push),
    .push_entry_o       (push_entry)
  );

  // decoupling queue
  hrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .stat_o       (q_stat)
  );

  // back end: window update, sort and median
  hrs_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_stat_i          (q_stat),
    .q_entry_i         (pop_entry),
    .pop_o             (pop),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .heart_rate_bpm_o  (heart_bpm),
    .breath_rate_bpm_o (breath_bpm),
    .used_fft_o        (m_axis_tuser)
  );

  assign m_axis_tdata = {breath_bpm, heart_bpm};

endmodule

// ===== design/hrs_front.sv =====
// front end: configuration registers, confidence smoothing and estimate selection
module hrs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         heart_rate_fft_i,
  input  logic [15:0]         heart_rate_peak_i,
  input  logic [15:0]         heart_confidence_i,
  input  logic [15:0]         breath_rate_fft_i,
  input  hrs_pkg::queue_stat_t q_stat_i,
  output logic                push_o,
  output hrs_pkg::entry_t     push_entry_o
);

  logic [15:0] conf_thr_q, diff_thr_q;
  logic [15:0] smooth_q, smooth_d;
  logic [16:0] conf_sum;
  logic [15:0] diff;
  logic [16:0] breath_sum;
  logic        use_fft;

  assign in_ready_o = ~q_stat_i.full;
  assign push_o     = in_valid_i & in_ready_o;

  assign conf_sum = {1'b0, heart_confidence_i} + {1'b0, smooth_q};
  assign smooth_d = conf_sum[16:1];
  assign diff = (heart_rate_fft_i >= heart_rate_peak_i) ?
                (heart_rate_fft_i - heart_rate_peak_i) :
                (heart_rate_peak_i - heart_rate_fft_i);
  assign use_fft = (smooth_d > conf_thr_q) | (diff < diff_thr_q);
  assign breath_sum = {1'b0, breath_rate_fft_i} + hrs_pkg::BREATH_ROUND;

  always_comb begin
    push_entry_o.chosen     = use_fft ? heart_rate_fft_i : heart_rate_peak_i;
    push_entry_o.used_fft   = use_fft;
    push_entry_o.breath_bpm = breath_sum[16] ? hrs_pkg::BPM_MAX : breath_sum[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q <= hrs_pkg::CONF_THR_RESET;
      diff_thr_q <= hrs_pkg::DIFF_THR_RESET;
      smooth_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          hrs_pkg::CFG_CONF_THR: conf_thr_q <= cfg_data_i;
          hrs_pkg::CFG_DIFF_THR: diff_thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_o) smooth_q <= smooth_d;
    end
  end

endmodule

// ===== design/hrs_queue.sv =====
// two-entry queue between front end and back end
module hrs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hrs_pkg::entry_t      push_entry_i,
  input  logic                 pop_i,
  output hrs_pkg::entry_t      pop_entry_o,
  output hrs_pkg::queue_stat_t stat_o
);

  hrs_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/hrs_back.sv =====
// back end: tagged sorted window, odd-even sort passes, median and output register
module hrs_back #(
  parameter int unsigned WINDOW_DEPTH = hrs_pkg::WINDOW_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hrs_pkg::queue_stat_t q_stat_i,
  input  hrs_pkg::entry_t      q_entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           heart_rate_bpm_o,
  output logic [7:0]           breath_rate_bpm_o,
  output logic                 used_fft_o
);

  localparam int unsigned TAG_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned MID_LO = (WINDOW_DEPTH - 1) / 2;
  localparam int unsigned MID_HI = WINDOW_DEPTH / 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [15:0]      val_q [WINDOW_DEPTH];
  logic [15:0]      val_d [WINDOW_DEPTH];
  logic [TAG_W-1:0] tag_q [WINDOW_DEPTH];
  logic [TAG_W-1:0] tag_d [WINDOW_DEPTH];
  logic [TAG_W-1:0] oldest_q, oldest_d;
  logic [TAG_W-1:0] pass_q, pass_d;
  logic             phase_q, phase_d;
  logic [7:0]       breath_q;
  logic             used_q;
  logic             out_valid_q;
  logic [7:0]       heart_out_q, breath_out_q;
  logic             used_out_q;
  logic [17:0]      median_sum;
  logic             load_out;

  assign pop_o    = (state_q == ST_IDLE) & ~q_stat_i.empty;
  assign load_out = (state_q == ST_DONE) & ~out_valid_q;

  assign median_sum = {2'b00, val_q[MID_LO]} + {2'b00, val_q[MID_HI]} + hrs_pkg::MEDIAN_ROUND;

  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    tag_d    = tag_q;
    oldest_d = oldest_q;
    pass_d   = pass_q;
    phase_d  = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          // the cell holding the oldest frame takes the new one
          for (int j = 0; j < WINDOW_DEPTH; j++) begin
            if (tag_q[j] == oldest_q) val_d[j] = q_entry_i.chosen;
          end
          oldest_d = (oldest_q == TAG_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
          pass_d   = '0;
          phase_d  = 1'b0;
          state_d  = ST_SORT;
        end
      end
      ST_SORT: begin
        for (int j = 0; j < WINDOW_DEPTH - 1; j++) begin
          if (((j % 2) == 1) == phase_q && val_q[j] > val_q[j+1]) begin
            val_d[j]   = val_q[j+1];
            val_d[j+1] = val_q[j];
            tag_d[j]   = tag_q[j+1];
            tag_d[j+1] = tag_q[j];
          end
        end
        phase_d = ~phase_q;
        pass_d  = pass_q + 1'b1;
        if (pass_q == TAG_W'(WINDOW_DEPTH - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      pass_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < WINDOW_DEPTH - 1; j++) begin
        val_q[j] <= '0;
        tag_q[j] <= TAG_W'(j + 1);
      end
      val_q[WINDOW_DEPTH-1] <= hrs_pkg::WINDOW_RESET_OLDEST;
      tag_q[WINDOW_DEPTH-1] <= '0;
    end else begin
      state_q  <= state_d;
      val_q    <= val_d;
      tag_q    <= tag_d;
      oldest_q <= oldest_d;
      pass_q   <= pass_d;
      phase_q  <= phase_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      breath_q <= q_entry_i.breath_bpm;
      used_q   <= q_entry_i.used_fft;
    end
    if (load_out) begin
      heart_out_q  <= (median_sum[17:9] > 9'd255) ? hrs_pkg::BPM_MAX : median_sum[16:9];
      breath_out_q <= breath_q;
      used_out_q   <= used_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign heart_rate_bpm_o  = heart_out_q;
  assign breath_rate_bpm_o = breath_out_q;
  assign used_fft_o        = used_out_q;

endmodule

// ===== design/hrs_checker.sv =====
// port-level checker of the heart rate select block and its bind
module hrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // results are never back to back: the output register empties before it loads again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("results delivered back to back");

endmodule

bind heart_rate_select_sliding_median hrs_checker u_hrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
